// ===== hdl/ycbcr_to_rgb_pixel_converter_assert.svh =====
// Assertion macros shared by the converter modules.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef YCBCR_TO_RGB_PIXEL_CONVERTER_ASSERT_SVH
`define YCBCR_TO_RGB_PIXEL_CONVERTER_ASSERT_SVH

// Condition must hold at every clock edge outside reset.
`define YCRGB_ASSERT_ALWAYS(name, expr, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define YCRGB_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define YCRGB_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/ycrgb_pkg.sv =====
// Shared types and constants for the YCbCr to RGB converter.
// No dependencies; imported by every module of the block.
package ycrgb_pkg;

    localparam int COUNT_BITS = 12;
    localparam int REG_W      = 12;
    localparam int CMP_W      = (COUNT_BITS + 1 > REG_W) ? COUNT_BITS + 1 : REG_W;
    localparam int PAD_W      = 2;

    // Signed Q13 coefficients
    localparam int COEF_W = 16;
    localparam logic signed [COEF_W-1:0] K_Y   = 16'sh253F;
    localparam logic signed [COEF_W-1:0] K_CRR = 16'sh3312;
    localparam logic signed [COEF_W-1:0] K_CRG = 16'shE5FC;
    localparam logic signed [COEF_W-1:0] K_CBG = 16'shF37E;
    localparam logic signed [COEF_W-1:0] K_CBB = 16'sh4093;

    localparam int SAMPLE_W  = 9;
    localparam int PROD_W    = COEF_W + SAMPLE_W;
    localparam int ACC_W     = PROD_W + 2;
    localparam int FRAC_BITS = 13;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef enum logic [0:0] {
        CFG_ROW_WIDTH = 1'b0,
        CFG_ROW_COUNT = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0]       luma;
        logic [7:0]       blue_chroma;
        logic [7:0]       red_chroma;
        logic [PAD_W-1:0] pad_bytes;
        logic             row_end;
        logic             frame_end;
    } t_pix_item;

    typedef struct packed {
        logic full;
        logic avail;
    } t_q_stat;

    // Floor divide by 2^13 and clamp to 0..255.
    function automatic logic [7:0] scale_clamp(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-FRAC_BITS-1:0] q;
        q = acc[ACC_W-1:FRAC_BITS];
        if (q < 0) begin
            return 8'd0;
        end else if (q > 255) begin
            return 8'd255;
        end
        return q[7:0];
    endfunction

endpackage

// ===== hdl/ycrgb_front.sv =====
// Front end: accepts pixels, tracks column and row, tags row and frame end.
// Holds the configuration registers. Depends on ycrgb_pkg and the assert header.
`include "ycbcr_to_rgb_pixel_converter_assert.svh"

module ycrgb_front
    import ycrgb_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [0:0]       i_cfg_index,
    input  logic [REG_W-1:0] i_cfg_data,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [7:0]       i_luma,
    input  logic [7:0]       i_blue_chroma,
    input  logic [7:0]       i_red_chroma,
    input  t_q_stat          i_q_stat,
    output logic             o_push,
    output t_pix_item        o_item
);

    logic [REG_W-1:0]      r_row_width, n_row_width;
    logic [REG_W-1:0]      r_row_count, n_row_count;
    logic [COUNT_BITS-1:0] r_col, n_col;
    logic [COUNT_BITS-1:0] r_row, n_row;
    logic                  accept;
    logic                  last_col;
    logic                  last_row;

    assign o_stall  = i_q_stat.full;
    assign accept   = i_valid && !i_q_stat.full;
    assign last_col = (CMP_W'(r_col) + CMP_W'(1)) >= CMP_W'(r_row_width);
    assign last_row = (CMP_W'(r_row) + CMP_W'(1)) >= CMP_W'(r_row_count);

    assign o_push                = accept;
    assign o_item.luma           = i_luma;
    assign o_item.blue_chroma    = i_blue_chroma;
    assign o_item.red_chroma     = i_red_chroma;
    assign o_item.pad_bytes      = last_col ? r_row_width[PAD_W-1:0] : '0;
    assign o_item.row_end        = last_col;
    assign o_item.frame_end      = last_col && last_row;

    always_comb begin
        n_row_width = r_row_width;
        n_row_count = r_row_count;
        if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_ROW_WIDTH: n_row_width = i_cfg_data;
                CFG_ROW_COUNT: n_row_count = i_cfg_data;
            endcase
        end
    end

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (accept) begin
            if (!last_col) begin
                n_col = r_col + COUNT_BITS'(1);
            end else begin
                n_col = '0;
                n_row = last_row ? '0 : r_row + COUNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_width <= REG_W'(1);
            r_row_count <= REG_W'(1);
            r_col       <= '0;
            r_row       <= '0;
        end else begin
            r_row_width <= n_row_width;
            r_row_count <= n_row_count;
            r_col       <= n_col;
            r_row       <= n_row;
        end
    end

    `YCRGB_ASSERT_NEXT(a_col_wrap, accept && last_col, r_col == '0, "column not cleared at row end")
    `YCRGB_ASSERT_NEXT(a_row_wrap, accept && last_col && last_row, r_row == '0, "row not cleared at frame end")

endmodule

// ===== hdl/ycrgb_queue.sv =====
// Four-entry queue of tagged pixels between the front and back ends.
// Depends on ycrgb_pkg and the assert header.
`include "ycbcr_to_rgb_pixel_converter_assert.svh"

module ycrgb_queue
    import ycrgb_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_pix_item i_item,
    input  logic      i_pop,
    output t_pix_item o_item,
    output t_q_stat   o_stat
);

    t_pix_item            r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [Q_PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [Q_CNT_W-1:0]   r_count, n_count;

    assign o_item       = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_stat.avail = (r_count != '0);

    always_comb begin
        n_wr_ptr = i_push ? r_wr_ptr + Q_PTR_W'(1) : r_wr_ptr;
        n_rd_ptr = i_pop  ? r_rd_ptr + Q_PTR_W'(1) : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + Q_CNT_W'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - Q_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    `YCRGB_ASSERT_IMP(a_no_overflow, i_push, r_count != Q_CNT_W'(Q_DEPTH), "push into full queue")
    `YCRGB_ASSERT_IMP(a_no_underflow, i_pop, r_count != '0, "pop from empty queue")
    `YCRGB_ASSERT_ALWAYS(a_count_max, r_count <= Q_CNT_W'(Q_DEPTH), "queue count out of range")

endmodule

// ===== hdl/ycrgb_back.sv =====
// Back end: Q13 multiplies, sum, floor shift and clamp, output register.
// Two register stages with per-stage valid; depends on ycrgb_pkg.
module ycrgb_back
    import ycrgb_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_q_stat          i_q_stat,
    input  t_pix_item        i_item,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [7:0]       o_blue,
    output logic [7:0]       o_green,
    output logic [7:0]       o_red,
    output logic [PAD_W-1:0] o_pad_bytes,
    output logic             o_row_end,
    output logic             o_frame_end
);

    logic signed [SAMPLE_W-1:0] y, cb, cr;
    logic signed [PROD_W-1:0]   r_p_y, r_p_cbb, r_p_crr, r_p_crg, r_p_cbg;
    logic [PAD_W-1:0]           r_s1_pad;
    logic                       r_s1_row_end, r_s1_frame_end;
    logic                       r_s1_valid;
    logic                       r_o_valid;
    logic                       out_ready;
    logic                       s1_take;
    logic signed [ACC_W-1:0]    acc_b, acc_g, acc_r;

    assign out_ready = !r_o_valid || !i_stall;
    assign s1_take   = !r_s1_valid || out_ready;
    assign o_pop     = i_q_stat.avail && s1_take;
    assign o_valid   = r_o_valid;

    assign y  = $signed({1'b0, i_item.luma}) - 9'sd16;
    assign cb = $signed({1'b0, i_item.blue_chroma}) - 9'sd128;
    assign cr = $signed({1'b0, i_item.red_chroma}) - 9'sd128;

    assign acc_b = ACC_W'(r_p_y) + ACC_W'(r_p_cbb);
    assign acc_g = ACC_W'(r_p_y) + ACC_W'(r_p_crg) + ACC_W'(r_p_cbg);
    assign acc_r = ACC_W'(r_p_y) + ACC_W'(r_p_crr);

    // Stage 1: products
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_p_y          <= K_Y * y;
            r_p_cbb        <= K_CBB * cb;
            r_p_crr        <= K_CRR * cr;
            r_p_crg        <= K_CRG * cr;
            r_p_cbg        <= K_CBG * cb;
            r_s1_pad       <= i_item.pad_bytes;
            r_s1_row_end   <= i_item.row_end;
            r_s1_frame_end <= i_item.frame_end;
        end
    end

    // Stage 2: sum, scale and clamp into the output register
    always_ff @(posedge i_clk) begin
        if (r_s1_valid && out_ready) begin
            o_blue      <= scale_clamp(acc_b);
            o_green     <= scale_clamp(acc_g);
            o_red       <= scale_clamp(acc_r);
            o_pad_bytes <= r_s1_pad;
            o_row_end   <= r_s1_row_end;
            o_frame_end <= r_s1_frame_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (s1_take) begin
                r_s1_valid <= i_q_stat.avail;
            end
            if (out_ready) begin
                r_o_valid <= r_s1_valid;
            end
        end
    end

endmodule

// ===== hdl/ycbcr_to_rgb_pixel_converter.sv =====
// YCbCr to RGB pixel converter (BT.601 video range, Q13 coefficients, clamp to 0..255).
// Takes one pixel per clock while o_stall is low and returns one RGB result per pixel
// in order, tagged with row end, frame end and the BMP row padding byte count
// (row_width mod 4 at row end). Sustained rate is one pixel per clock while i_stall is
// low, set by the two-stage multiply and clamp pipeline. A four-entry queue between
// the counters and the arithmetic absorbs output stalls, so input stall rises only
// once that queue is full. Write row_width (index 0) and row_count (index 1) only
// while the block is idle; both reset to 1; 0 behaves as 1, but row_width 0 tags pad 0.
// Depends on ycrgb_pkg, ycrgb_front, ycrgb_queue and ycrgb_back.
module ycbcr_to_rgb_pixel_converter
    import ycrgb_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [0:0]       i_cfg_index,
    input  logic [REG_W-1:0] i_cfg_data,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [7:0]       i_luma,
    input  logic [7:0]       i_blue_chroma,
    input  logic [7:0]       i_red_chroma,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [7:0]       o_blue,
    output logic [7:0]       o_green,
    output logic [7:0]       o_red,
    output logic [PAD_W-1:0] o_pad_bytes,
    output logic             o_row_end,
    output logic             o_frame_end
);

    t_q_stat   q_stat;
    t_pix_item push_item;
    t_pix_item head_item;
    logic      push;
    logic      pop;

    ycrgb_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_luma        (i_luma),
        .i_blue_chroma (i_blue_chroma),
        .i_red_chroma  (i_red_chroma),
        .i_q_stat      (q_stat),
        .o_push        (push),
        .o_item        (push_item)
    );

    ycrgb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_item  (head_item),
        .o_stat  (q_stat)
    );

    ycrgb_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_stat    (q_stat),
        .i_item      (head_item),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_blue      (o_blue),
        .o_green     (o_green),
        .o_red       (o_red),
        .o_pad_bytes (o_pad_bytes),
        .o_row_end   (o_row_end),
        .o_frame_end (o_frame_end)
    );

endmodule
